// ===== rtl/hhe_pkg.sv =====
`timescale 1ns / 1ps

package hhe_pkg;

   localparam int unsigned SCAN_LIMIT = 2048;
   localparam int unsigned HOST_MAX   = 255;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 16;
   localparam int unsigned HOST_CNT_W = $clog2(HOST_MAX + 2);
   localparam int unsigned MATCH_W    = 3;
   localparam int unsigned HIST_DEPTH = 9;

   localparam int unsigned MIN_LENGTH = 18;
   localparam int unsigned SEEK_POS   = 14;
   localparam int unsigned MIN_SCAN   = MIN_LENGTH + SEEK_POS;
   localparam int unsigned SIG_POS    = 3;
   localparam int unsigned LINE_SKIP  = 2;
   localparam int unsigned LINE_ROOM  = 8;
   localparam int unsigned TAG_LEN    = 6;
   localparam int unsigned MATCH_NONE = 7;

   localparam logic [BYTE_W-1:0] CR_BYTE  = 8'h0D;
   localparam logic [31:0]       SIG_GET  = 32'h4745_5420;
   localparam logic [31:0]       SIG_POST = 32'h504F_5354;
   localparam logic [47:0]       HTTP_TAG = " HTTP/";
   localparam logic [47:0]       HOST_TAG = "Host: ";

   localparam logic KIND_HOST    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      ST_NOT_HTTP = 2'd0,
      ST_NO_HOST  = 2'd1,
      ST_FOUND    = 2'd2,
      ST_TOO_LONG = 2'd3
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0]  payload_length;
      logic [BYTE_W-1:0] payload_byte;
      logic              first_byte;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic              result_kind;
      logic [BYTE_W-1:0] host_byte;
      status_type        status;
      logic              end_of_packet_result;
   } rsp_item_type;

   function automatic logic [BYTE_W-1:0] host_tag_char(input logic [MATCH_W-1:0] idx);
      logic [BYTE_W-1:0] ch;
      unique case (idx)
         3'd0: ch = HOST_TAG[47:40];
         3'd1: ch = HOST_TAG[39:32];
         3'd2: ch = HOST_TAG[31:24];
         3'd3: ch = HOST_TAG[23:16];
         3'd4: ch = HOST_TAG[15:8];
         3'd5: ch = HOST_TAG[7:0];
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

// ===== rtl/hhe_in_stage.sv =====
`timescale 1ns / 1ps

module hhe_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hhe_pkg::req_item_type in_item,
   input  logic                 consume,
   output logic                 item_valid,
   output hhe_pkg::req_item_type item
);
   import hhe_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready = !valid_ff || consume;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/hhe_parser.sv =====
`timescale 1ns / 1ps

module hhe_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  hhe_pkg::req_item_type item,
   output logic                  res_valid,
   output hhe_pkg::rsp_item_type res
);
   import hhe_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SIG  = 3'd1,
      PH_SEEK = 3'd2,
      PH_LINE = 3'd3,
      PH_HOST = 3'd4,
      PH_DONE = 3'd5
   } phase_type;

   localparam logic [POS_W-1:0]      SCAN_LIMIT_C = POS_W'(SCAN_LIMIT);
   localparam logic [POS_W-1:0]      MIN_LENGTH_C = POS_W'(MIN_LENGTH);
   localparam logic [POS_W-1:0]      MIN_SCAN_C   = POS_W'(MIN_SCAN);
   localparam logic [POS_W-1:0]      SIG_POS_C    = POS_W'(SIG_POS);
   localparam logic [POS_W-1:0]      SEEK_POS_C   = POS_W'(SEEK_POS);
   localparam logic [POS_W-1:0]      SKIP_C       = POS_W'(LINE_SKIP);
   localparam logic [POS_W:0]        NEED_C       = (POS_W + 1)'(LINE_SKIP + LINE_ROOM);
   localparam logic [POS_W-1:0]      POS_MAX_C    = '1;
   localparam logic [MATCH_W-1:0]    TAG_LEN_C    = MATCH_W'(TAG_LEN);
   localparam logic [MATCH_W-1:0]    MATCH_NONE_C = MATCH_W'(MATCH_NONE);
   localparam logic [HOST_CNT_W-1:0] HOST_MAX_C   = HOST_CNT_W'(HOST_MAX);
   localparam logic [HOST_CNT_W-1:0] HOST_OVER_C  = HOST_CNT_W'(HOST_MAX + 1);

   phase_type             phase_ff, phase_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [BYTE_W-1:0]     hist_ff [HIST_DEPTH];
   logic [BYTE_W-1:0]     hist_in [HIST_DEPTH];
   logic [POS_W-1:0]      line_start_ff, line_start_in;
   logic [MATCH_W-1:0]    match_ff, match_in;
   logic [HOST_CNT_W-1:0] host_count_ff, host_count_in;

   logic [POS_W-1:0]  scan;
   logic [POS_W-1:0]  pos_cur;
   logic [POS_W-1:0]  offset;
   logic [BYTE_W-1:0] b;
   logic [31:0]       sig_word;
   logic              verdict_valid;
   status_type        verdict;
   logic              host_valid;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      hist_in       = hist_ff;
      line_start_in = line_start_ff;
      match_in      = match_ff;
      host_count_in = host_count_ff;
      verdict_valid = 1'b0;
      verdict       = ST_NOT_HTTP;
      host_valid    = 1'b0;
      b             = item.payload_byte;
      scan          = (item.payload_length < SCAN_LIMIT_C) ? item.payload_length : SCAN_LIMIT_C;

      if (item.first_byte) begin
         phase_in      = PH_SIG;
         pos_in        = '0;
         line_start_in = '0;
         match_in      = '0;
         host_count_in = '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_in[i] = '0;
         end
         if (item.payload_length < MIN_LENGTH_C || scan < MIN_SCAN_C) begin
            verdict_valid = 1'b1;
            verdict       = ST_NOT_HTTP;
         end
      end

      pos_cur  = pos_in;
      offset   = pos_cur - line_start_in;
      sig_word = {hist_in[2], hist_in[1], hist_in[0], b};

      if (!verdict_valid && (phase_in == PH_SIG || phase_in == PH_SEEK ||
                             phase_in == PH_LINE || phase_in == PH_HOST)) begin
         unique case (phase_in)
            PH_SIG: begin
               if (pos_cur >= SIG_POS_C) begin
                  if (sig_word != SIG_GET && sig_word != SIG_POST) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_NOT_HTTP;
                  end else begin
                     phase_in = PH_SEEK;
                  end
               end
            end
            PH_SEEK: begin
               if (pos_cur >= SEEK_POS_C && b == CR_BYTE) begin
                  if ({hist_in[8], hist_in[7], hist_in[6], hist_in[5], hist_in[4],
                       hist_in[3]} != HTTP_TAG) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_NOT_HTTP;
                  end else if ({1'b0, pos_cur} + NEED_C > {1'b0, scan}) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_NO_HOST;
                  end else begin
                     line_start_in = pos_cur + SKIP_C;
                     match_in      = '0;
                     phase_in      = PH_LINE;
                  end
               end
            end
            PH_LINE: begin
               if (pos_cur >= line_start_ff || item.first_byte) begin
                  if (b == CR_BYTE) begin
                     if ({1'b0, pos_cur} + NEED_C > {1'b0, scan}) begin
                        verdict_valid = 1'b1;
                        verdict       = ST_NO_HOST;
                     end else begin
                        line_start_in = pos_cur + SKIP_C;
                        match_in      = '0;
                     end
                  end else if (match_in < TAG_LEN_C) begin
                     if (offset == POS_W'(match_in) && b == host_tag_char(match_in)) begin
                        match_in = match_in + 1'b1;
                        if (match_in == TAG_LEN_C) begin
                           phase_in      = PH_HOST;
                           host_count_in = '0;
                        end
                     end else begin
                        match_in = MATCH_NONE_C;
                     end
                  end
               end
            end
            PH_HOST: begin
               if (b == CR_BYTE) begin
                  verdict_valid = 1'b1;
                  verdict       = (host_count_in > HOST_MAX_C) ? ST_TOO_LONG : ST_FOUND;
               end else if (host_count_in < HOST_MAX_C) begin
                  host_valid    = 1'b1;
                  host_count_in = host_count_in + 1'b1;
               end else begin
                  host_count_in = HOST_OVER_C;
               end
            end
            default: begin
            end
         endcase

         for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            hist_in[i] = hist_in[i-1];
         end
         hist_in[0] = b;

         if (!verdict_valid && ({1'b0, pos_cur} + 1'b1 >= {1'b0, scan})) begin
            verdict_valid = 1'b1;
            verdict = (phase_in == PH_SIG || phase_in == PH_SEEK) ? ST_NOT_HTTP : ST_NO_HOST;
         end
         if (pos_cur != POS_MAX_C) begin
            pos_in = pos_cur + 1'b1;
         end
      end

      if (item.last_byte && !verdict_valid &&
          (phase_in == PH_SIG || phase_in == PH_SEEK ||
           phase_in == PH_LINE || phase_in == PH_HOST)) begin
         verdict_valid = 1'b1;
         verdict = (phase_in == PH_SIG || phase_in == PH_SEEK) ? ST_NOT_HTTP : ST_NO_HOST;
      end

      if (verdict_valid) begin
         phase_in = item.last_byte ? PH_IDLE : PH_DONE;
      end else if (item.last_byte) begin
         phase_in = PH_IDLE;
      end

      res_valid = verdict_valid || (host_valid && !item.last_byte);
      if (verdict_valid) begin
         res.result_kind          = KIND_VERDICT;
         res.host_byte            = '0;
         res.status               = verdict;
         res.end_of_packet_result = 1'b1;
      end else begin
         res.result_kind          = KIND_HOST;
         res.host_byte            = b;
         res.status               = ST_NOT_HTTP;
         res.end_of_packet_result = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         pos_ff        <= '0;
         line_start_ff <= '0;
         match_ff      <= '0;
         host_count_ff <= '0;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (fire) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         line_start_ff <= line_start_in;
         match_ff      <= match_in;
         host_count_ff <= host_count_in;
         hist_ff       <= hist_in;
      end
   end

endmodule

// ===== rtl/hhe_out_stage.sv =====
`timescale 1ns / 1ps

module hhe_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  res_valid,
   input  hhe_pkg::rsp_item_type res,
   output logic                  space,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hhe_pkg::rsp_item_type out_item
);
   import hhe_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign space = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (space) begin
         valid_in = fire && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (fire && res_valid) begin
         item_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/http_host_header_extractor.sv =====
`timescale 1ns / 1ps

// Channel   Direction  tdata                                   tuser        tlast
// req_      in         [7:0] payload_byte, [23:8] payload_len  first_byte   last_byte
// rsp_      out        [7:0] host_byte, [9:8] status, 0 pad    result_kind  end_of_packet
//
// Each request is parsed while it sits in the input register, and its result is loaded
// into the result register as the request leaves the input register. One request is
// taken every cycle while the result register is not stalled; the parse state advances
// only as requests leave the input register. Reset is synchronous and clears all parse
// and handshake state. A stalled result register holds the parser, and req_tready falls
// once the input register is also full.

module http_host_header_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // payload_byte, payload_length
   input  logic        req_tuser,   // first_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // host_byte, status, zero pad
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast
);
   import hhe_pkg::*;

   req_item_type in_item;
   req_item_type item;
   rsp_item_type res;
   rsp_item_type out_item;
   logic         item_valid;
   logic         res_valid;
   logic         space;
   logic         fire;

   assign in_item.payload_byte   = req_tdata[7:0];
   assign in_item.payload_length = req_tdata[23:8];
   assign in_item.first_byte     = req_tuser;
   assign in_item.last_byte      = req_tlast;

   assign fire = item_valid && space;

   hhe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .consume    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   hhe_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   hhe_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res_valid (res_valid),
      .res       (res),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {6'b0, out_item.status, out_item.host_byte};
   assign rsp_tuser = out_item.result_kind;
   assign rsp_tlast = out_item.end_of_packet_result;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import hhe_pkg::*;

   localparam int unsigned ITEM_TARGET    = 750;
   localparam int unsigned STEADY_FROM    = 620;
   localparam int unsigned HOLD_CYCLES    = 150;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam int unsigned REPORT_LIMIT   = 10;

   typedef enum {PH_IDLE, PH_SIG, PH_SEEK, PH_LINE, PH_HOST, PH_DONE} parse_phase_type;

   class host_header_tracker;
      parse_phase_type phase = PH_IDLE;
      logic [15:0]    position;
      logic [7:0]     recent[HIST_DEPTH];
      int unsigned    line_start;
      int unsigned    match_count;
      int unsigned    host_count;
      rsp_item_type   awaited_results[$];
      int unsigned    mismatches;

      function new();
         clear_packet();
         mismatches = 0;
      endfunction

      function void clear_packet();
         position = '0;
         foreach (recent[i]) recent[i] = '0;
         line_start = 0;
         match_count = 0;
         host_count = 0;
      endfunction

      function int unsigned awaited_count();
         return awaited_results.size();
      endfunction

      // Returns 1 when too few scanned bytes remain for another header line.
      function bit open_line(int unsigned p, int unsigned scan);
         if (p + LINE_SKIP + LINE_ROOM > scan) return 1'b1;
         line_start = p + LINE_SKIP;
         match_count = 0;
         phase = PH_LINE;
         return 1'b0;
      endfunction

      function status_type unfinished_verdict();
         return (phase == PH_SIG || phase == PH_SEEK) ? ST_NOT_HTTP : ST_NO_HOST;
      endfunction

      function void note_request(logic [7:0] b, logic [15:0] len, bit first, bit last);
         int unsigned  scan;
         int unsigned  pos;
         bit           decided;
         bit           host_valid;
         bit           tag_ok;
         status_type   verdict;
         rsp_item_type item;
         scan = (len < SCAN_LIMIT) ? 32'(len) : SCAN_LIMIT;
         decided = 1'b0;
         host_valid = 1'b0;
         verdict = ST_NOT_HTTP;
         if (first) begin
            clear_packet();
            phase = PH_SIG;
            if (len < MIN_LENGTH || scan < MIN_SCAN) decided = 1'b1;
         end
         if (!decided && phase != PH_IDLE && phase != PH_DONE) begin
            pos = 32'(position);
            case (phase)
               PH_SIG: begin
                  if (pos >= SIG_POS) begin
                     if ({recent[2], recent[1], recent[0], b} != SIG_GET &&
                         {recent[2], recent[1], recent[0], b} != SIG_POST) begin
                        decided = 1'b1;
                        verdict = ST_NOT_HTTP;
                     end else begin
                        phase = PH_SEEK;
                     end
                  end
               end
               PH_SEEK: begin
                  if (pos >= SEEK_POS && b == CR_BYTE) begin
                     tag_ok = 1'b1;
                     for (int k = 0; k < TAG_LEN; k++)
                        if (recent[8 - k] != HTTP_TAG[47 - 8 * k -: 8]) tag_ok = 1'b0;
                     if (!tag_ok) begin
                        decided = 1'b1;
                        verdict = ST_NOT_HTTP;
                     end else if (open_line(pos, scan)) begin
                        decided = 1'b1;
                        verdict = ST_NO_HOST;
                     end
                  end
               end
               PH_LINE: begin
                  if (pos >= line_start) begin
                     if (b == CR_BYTE) begin
                        if (open_line(pos, scan)) begin
                           decided = 1'b1;
                           verdict = ST_NO_HOST;
                        end
                     end else if (match_count < TAG_LEN) begin
                        if (pos - line_start == match_count &&
                            b == HOST_TAG[47 - 8 * match_count -: 8]) begin
                           match_count++;
                           if (match_count == TAG_LEN) begin
                              phase = PH_HOST;
                              host_count = 0;
                           end
                        end else begin
                           match_count = MATCH_NONE;
                        end
                     end
                  end
               end
               PH_HOST: begin
                  if (b == CR_BYTE) begin
                     decided = 1'b1;
                     verdict = (host_count > HOST_MAX) ? ST_TOO_LONG : ST_FOUND;
                  end else if (host_count < HOST_MAX) begin
                     host_valid = 1'b1;
                     host_count++;
                  end else begin
                     host_count = HOST_MAX + 1;
                  end
               end
               default: ;
            endcase
            for (int k = HIST_DEPTH - 1; k > 0; k--) recent[k] = recent[k - 1];
            recent[0] = b;
            if (!decided && pos + 1 >= scan) begin
               decided = 1'b1;
               verdict = unfinished_verdict();
            end
            if (position != 16'hFFFF) position++;
         end
         if (last && !decided && phase != PH_IDLE && phase != PH_DONE) begin
            decided = 1'b1;
            verdict = unfinished_verdict();
         end
         if (decided) begin
            phase = last ? PH_IDLE : PH_DONE;
            item.result_kind = KIND_VERDICT;
            item.host_byte = '0;
            item.status = verdict;
            item.end_of_packet_result = 1'b1;
            awaited_results.push_back(item);
         end else if (last) begin
            phase = PH_IDLE;
         end else if (host_valid) begin
            item.result_kind = KIND_HOST;
            item.host_byte = b;
            item.status = ST_NOT_HTTP;
            item.end_of_packet_result = 1'b0;
            awaited_results.push_back(item);
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result kind=%0d byte=%02h status=%0d last=%0d",
                        $realtime, got.result_kind, got.host_byte, got.status,
                        got.end_of_packet_result);
            return;
         end
         want = awaited_results.pop_front();
         if (want.result_kind !== got.result_kind || want.host_byte !== got.host_byte ||
             want.status !== got.status ||
             want.end_of_packet_result !== got.end_of_packet_result) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: expected kind=%0d byte=%02h status=%0d last=%0d, %s%0d %02h %0d %0d",
                        $realtime, want.result_kind, want.host_byte, want.status,
                        want.end_of_packet_result, "got ", got.result_kind, got.host_byte,
                        got.status, got.end_of_packet_result);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // payload_byte, payload_length
   logic        req_tuser;   // first_byte
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // host_byte, status, zero pad
   logic        rsp_tuser;   // result_kind
   logic        rsp_tlast;

   host_header_tracker tracker;
   logic [7:0]         packet_bytes[$];
   int unsigned        sent_count;
   bit                 steady_tail;
   bit                 pressure_request;

   http_host_header_extractor DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_request(logic [7:0] b, logic [15:0] len, bit first, bit last);
      if (!steady_tail && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {len, b};
      req_tuser <= first;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(b, len, first, last);
      sent_count++;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) packet_bytes.push_back(s[i]);
   endtask

   task automatic add_letters(int unsigned count);
      repeat (count) packet_bytes.push_back(8'($urandom_range(97, 122)));
   endtask

   // The byte after a carriage return is skipped by the block, so it need not be a line feed.
   task automatic add_line_end();
      packet_bytes.push_back(CR_BYTE);
      if ($urandom_range(0, 7) == 0) packet_bytes.push_back(8'($urandom_range(0, 255)));
      else packet_bytes.push_back(8'h0A);
   endtask

   task automatic add_host_line(bit long_host, output bit open_end);
      string       prefix;
      int          bad_index;
      int unsigned host_len;
      logic [7:0]  c;
      prefix = "Host: ";
      bad_index = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5) : -1;
      for (int k = 0; k < 6; k++)
         packet_bytes.push_back((k == bad_index) ? 8'($urandom_range(32, 126)) : prefix[k]);
      host_len = long_host ? $urandom_range(HOST_MAX - 1, HOST_MAX + 3) : $urandom_range(0, 24);
      repeat (host_len) begin
         if ($urandom_range(0, 4) == 0) begin
            c = 8'($urandom_range(0, 255));
            if (c == CR_BYTE) c = 8'h2E;
         end else begin
            c = 8'($urandom_range(97, 122));
         end
         packet_bytes.push_back(c);
      end
      open_end = !long_host && $urandom_range(0, 7) == 0;
      if (!open_end) add_line_end();
   endtask

   task automatic build_request(bit long_host);
      int unsigned header_count;
      int unsigned host_slot;
      bit          with_host;
      bit          open_end;
      packet_bytes.delete();
      open_end = 1'b0;
      if ($urandom_range(0, 1)) add_text("GET /");
      else add_text("POST /");
      add_letters($urandom_range(0, 9));
      add_text(" HTTP/1.1");
      add_line_end();
      with_host = long_host || $urandom_range(0, 4) != 0;
      header_count = $urandom_range(0, 3);
      host_slot = $urandom_range(0, header_count);
      for (int i = 0; i <= header_count; i++) begin
         if (with_host && i == host_slot) begin
            add_host_line(long_host, open_end);
            if (open_end) return;
         end
         if (i < header_count) begin
            case ($urandom_range(0, 3))
               0: add_text("Accept: ");
               1: add_text("Hos: ");
               2: add_text("Hostname: ");
               default: add_text("Cookie: ");
            endcase
            add_letters($urandom_range(0, 10));
            add_line_end();
         end
      end
      add_line_end();
      add_letters($urandom_range(0, 12));
   endtask

   task automatic build_noise();
      packet_bytes.delete();
      if ($urandom_range(0, 1)) add_text("GET ");
      repeat ($urandom_range(1, 40)) packet_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_packet(bit with_last);
      int unsigned n;
      logic [15:0] len;
      int          change_at;
      n = packet_bytes.size();
      case ($urandom_range(0, 9))
         0: len = 16'(n + $urandom_range(1, 100));
         1: len = 16'($urandom_range(0, n));
         2: len = 16'($urandom_range(0, 65535));
         3: len = 16'($urandom_range(SCAN_LIMIT + 1, 65535));
         default: len = 16'(n);
      endcase
      change_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : -1;
      for (int i = 0; i < n; i++) begin
         if (i == change_at) len = 16'($urandom_range(0, n));
         send_request(packet_bytes[i], len, i == 0, with_last && i == n - 1);
      end
   endtask

   initial begin
      rsp_item_type got;
      int unsigned  stall_left;
      int unsigned  hold_left;
      bit           ready_next;
      rsp_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.result_kind = rsp_tuser;
            got.host_byte = rsp_tdata[7:0];
            got.status = status_type'(rsp_tdata[9:8]);
            got.end_of_packet_result = rsp_tlast;
            tracker.check_result(got);
         end
         if (pressure_request) begin
            hold_left = HOLD_CYCLES;
            pressure_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      int unsigned stuck_cycles;
      stuck_cycles = 0;
      do @(posedge clock); while (reset !== 1'b0);
      while (stuck_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stuck_cycles = 0;
         else stuck_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int unsigned packet_number;
      tracker = new();
      sent_count = 0;
      steady_tail = 1'b0;
      pressure_request = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      req_tlast <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Requests outside any packet, one-request packets, too-short lengths,
      // a bad signature and a packet cut off by the next first byte.
      send_request(8'h00, 16'h0000, 1'b0, 1'b0);
      send_request(8'hFF, 16'hFFFF, 1'b0, 1'b1);
      send_request("G", 16'd0, 1'b1, 1'b1);
      send_request(8'hFF, 16'hFFFF, 1'b1, 1'b0);
      send_request(8'h00, 16'hFFFF, 1'b0, 1'b1);
      send_request("G", 16'd17, 1'b1, 1'b0);
      send_request("E", 16'd17, 1'b0, 1'b0);
      send_request("T", 16'd17, 1'b0, 1'b1);
      send_request("G", 16'd31, 1'b1, 1'b1);
      send_request("G", 16'd40, 1'b1, 1'b0);
      send_request("E", 16'd40, 1'b0, 1'b0);
      send_request("X", 16'd40, 1'b0, 1'b0);
      send_request(" ", 16'd40, 1'b0, 1'b0);
      send_request("z", 16'd40, 1'b0, 1'b1);
      send_request("P", 16'd32, 1'b1, 1'b0);
      send_request("O", 16'd32, 1'b0, 1'b0);
      send_request("S", 16'd32, 1'b0, 1'b0);
      send_request("T", 16'd32, 1'b0, 1'b0);
      send_request(" ", 16'd32, 1'b0, 1'b0);
      send_request("G", 16'd2048, 1'b1, 1'b0);
      send_request("E", 16'd2048, 1'b0, 1'b1);

      pressure_request = 1'b1;
      packet_number = 0;
      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= STEADY_FROM) steady_tail = 1'b1;
         if (packet_number == 2 || $urandom_range(0, 39) == 0) begin
            build_request(1'b1);
         end else begin
            if ($urandom_range(0, 9) == 0) build_noise();
            else build_request(1'b0);
            if ($urandom_range(0, 7) == 0)
               packet_bytes[$urandom_range(0, packet_bytes.size() - 1)] =
                  8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0)
               packet_bytes = packet_bytes[0:$urandom_range(0, packet_bytes.size() - 1)];
         end
         send_packet($urandom_range(0, 11) != 0);
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
               send_request(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 1'b0,
                            1'($urandom_range(0, 1)));
         packet_number++;
      end
      req_tvalid <= 1'b0;

      while (tracker.awaited_count() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.awaited_count() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hhe_pkg.sv
rtl/hhe_in_stage.sv
rtl/hhe_parser.sv
rtl/hhe_out_stage.sv
rtl/http_host_header_extractor.sv
test/tb_top.sv
